/* src/kelsa_pkg.sv */
`default_nettype none

package kelsa_pkg;

  localparam int NUM_SLOTS_DEF = 32;

  localparam int KEY_W    = 16;
  localparam int TIME_W   = 32;
  localparam int RADIUS_W = 20;
  localparam int DECAY_W  = 20;
  localparam int FT_W     = 16;
  localparam int PROD_W   = DECAY_W + FT_W;
  localparam int REQ_W    = 2;
  localparam int SIDX_W   = 5;
  localparam int OUTC_W   = 2;

  typedef logic [REQ_W-1:0]  req_t;
  typedef logic [OUTC_W-1:0] outc_t;

  localparam req_t REQ_ALLOC = 2'd0;
  localparam req_t REQ_TICK  = 2'd1;
  localparam req_t REQ_CLEAR = 2'd2;

  localparam outc_t OUTC_KEY_MATCH = 2'd0;
  localparam outc_t OUTC_EXPIRED   = 2'd1;
  localparam outc_t OUTC_FORCED    = 2'd2;
  localparam outc_t OUTC_DONE      = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [TIME_W-1:0]   expiry;
    logic [RADIUS_W-1:0] radius;
    logic [DECAY_W-1:0]  decay;
  } slot_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

/* src/kelsa_slot_ram.sv */
`default_nettype none

module kelsa_slot_ram #(
  parameter int NUM_SLOTS = 32
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          clr,
  input  wire                          wr_en,
  input  wire [$clog2(NUM_SLOTS)-1:0]  wr_addr,
  input  kelsa_pkg::slot_t             wr_data,
  input  wire                          rd_en,
  input  wire [$clog2(NUM_SLOTS)-1:0]  rd_addr,
  output kelsa_pkg::slot_t             rd_q
);
  import kelsa_pkg::*;

  slot_t                mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] valid;
  slot_t                rd_data;
  logic                 rd_hit;

  // Entries never written since reset or the last clear read as all zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (clr) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
      rd_hit  <= valid[rd_addr];
    end
  end

  assign rd_q = rd_hit ? rd_data : '0;

endmodule

`default_nettype wire

/* src/kelsa_decay_unit.sv */
`default_nettype none

module kelsa_decay_unit #(
  parameter int NUM_SLOTS = 32
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                in_vld,
  input  wire [$clog2(NUM_SLOTS)-1:0]        in_addr,
  input  kelsa_pkg::slot_t                   in_slot,
  input  wire [kelsa_pkg::TIME_W-1:0]        now,
  input  wire [kelsa_pkg::FT_W-1:0]          frame_time,
  output logic                               wr_en,
  output logic [$clog2(NUM_SLOTS)-1:0]       wr_addr,
  output kelsa_pkg::slot_t                   wr_data
);
  import kelsa_pkg::*;

  logic                         p_vld;
  logic [$clog2(NUM_SLOTS)-1:0] p_addr;
  slot_t                        p_slot;
  logic [PROD_W-1:0]            p_prod;
  logic                         p_exp;
  logic [RADIUS_W-1:0]          dec;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else begin
      p_vld <= in_vld;
    end
  end

  // The product is registered before the saturating subtract.
  always_ff @(posedge clk) begin
    if (in_vld) begin
      p_addr <= in_addr;
      p_slot <= in_slot;
      p_prod <= PROD_W'(in_slot.decay) * PROD_W'(frame_time);
      p_exp  <= in_slot.expiry < now;
    end
  end

  assign dec = p_prod[PROD_W-1:FT_W];

  always_comb begin
    wr_en   = p_vld && (p_slot.radius != '0);
    wr_addr = p_addr;
    wr_data = p_slot;
    if (p_exp || (dec >= p_slot.radius)) begin
      wr_data.radius = '0;
    end else begin
      wr_data.radius = p_slot.radius - dec;
    end
  end

endmodule

`default_nettype wire

/* src/keyed_expiring_light_slot_allocator_unit.sv */
`default_nettype none
// Allocate and tick beats scan the whole slot table before their result is valid:
// the slot table is one memory with one read and one write port, scanned one slot per cycle.
// Clear and unused beats skip the scan and go straight to the done state. A new beat is
// accepted only after the previous result has entered the output register, so beats never
// overlap; while the output stalls, the block waits in the done state and takes no new beat.
// Synchronous reset clears per-slot valid bits at once; there is no clearing pass.
module keyed_expiring_light_slot_allocator_unit #(
  parameter int NUM_SLOTS = kelsa_pkg::NUM_SLOTS_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire [kelsa_pkg::REQ_W-1:0]       req_type,
  input  wire [kelsa_pkg::KEY_W-1:0]       light_key,
  input  wire [kelsa_pkg::TIME_W-1:0]      now_ms,
  input  wire [kelsa_pkg::RADIUS_W-1:0]    new_radius,
  input  wire [kelsa_pkg::TIME_W-1:0]      new_expiry,
  input  wire [kelsa_pkg::DECAY_W-1:0]     new_decay,
  input  wire [kelsa_pkg::FT_W-1:0]        frame_time,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [kelsa_pkg::SIDX_W-1:0]     slot_index,
  output logic [kelsa_pkg::OUTC_W-1:0]     outcome
);
  import kelsa_pkg::*;

  localparam int IDX_W = $clog2(NUM_SLOTS);
  localparam int CNT_W = $clog2(NUM_SLOTS + 2);
  // The scan ends once the last read has passed through the decay unit.
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_SLOTS + 1);
  localparam logic [CNT_W-1:0] CNT_RD   = CNT_W'(NUM_SLOTS);

  state_t state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  // Latched request beat.
  req_t                req_r;
  logic [KEY_W-1:0]    key_r;
  logic [TIME_W-1:0]   now_r;
  logic [RADIUS_W-1:0] rad_r;
  logic [TIME_W-1:0]   exp_r;
  logic [DECAY_W-1:0]  dcy_r;
  logic [FT_W-1:0]     ft_r;

  // Allocation search results, lowest index wins.
  logic             found_key, found_exp;
  logic [IDX_W-1:0] key_idx, exp_idx;

  // Read pipeline: s1 marks that read data for s1_addr is on the RAM output.
  logic             s1_vld;
  logic [IDX_W-1:0] s1_addr;

  logic [SIDX_W-1:0] res_idx;
  outc_t             res_code;

  logic              accept;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  slot_t             rd_q;
  logic              ram_wr_en;
  logic [IDX_W-1:0]  ram_wr_addr;
  slot_t             ram_wr_data;
  logic              clr;
  logic              key_hit, exp_hit;
  logic              scan_end;
  logic [IDX_W-1:0]  alloc_idx;
  outc_t             alloc_code;
  logic [IDX_W+SIDX_W-1:0] alloc_idx_ext;
  logic              out_free;

  logic              du_in_vld;
  logic              du_wr_en;
  logic [IDX_W-1:0]  du_wr_addr;
  slot_t             du_wr_data;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign clr      = accept && (req_type == REQ_CLEAR);
  assign out_free = !out_valid || out_ready;

  assign rd_en    = (state == ST_SCAN) && (cnt < CNT_RD);
  assign rd_addr  = cnt[IDX_W-1:0];
  assign scan_end = (state == ST_SCAN) && (cnt == CNT_LAST);

  // A zero key never matches; unwritten slots read as key 0 and expiry 0.
  assign key_hit = s1_vld && (key_r != '0) && (rd_q.key == key_r);
  assign exp_hit = s1_vld && (rd_q.expiry < now_r);

  always_comb begin
    if (found_key) begin
      alloc_idx  = key_idx;
      alloc_code = OUTC_KEY_MATCH;
    end else if (found_exp) begin
      alloc_idx  = exp_idx;
      alloc_code = OUTC_EXPIRED;
    end else begin
      alloc_idx  = '0;
      alloc_code = OUTC_FORCED;
    end
  end

  // The reported index is the low five bits of the slot number.
  assign alloc_idx_ext = (IDX_W + SIDX_W)'(alloc_idx);

  assign du_in_vld = s1_vld && (req_r == REQ_TICK);

  kelsa_slot_ram #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_ram (
    .clk     (clk),
    .rst     (rst),
    .clr     (clr),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_q    (rd_q)
  );

  kelsa_decay_unit #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_decay (
    .clk        (clk),
    .rst        (rst),
    .in_vld     (du_in_vld),
    .in_addr    (s1_addr),
    .in_slot    (rd_q),
    .now        (now_r),
    .frame_time (ft_r),
    .wr_en      (du_wr_en),
    .wr_addr    (du_wr_addr),
    .wr_data    (du_wr_data)
  );

  // Next state and the shared write port. Tick write-backs and the final
  // allocate write never fall in the same cycle.
  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    ram_wr_en   = du_wr_en;
    ram_wr_addr = du_wr_addr;
    ram_wr_data = du_wr_data;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cnt_next = '0;
          if ((req_type == REQ_ALLOC) || (req_type == REQ_TICK)) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        cnt_next = cnt + 1'b1;
        if (scan_end) begin
          state_next = ST_DONE;
          if (req_r == REQ_ALLOC) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = alloc_idx;
            ram_wr_data = '{key: key_r, expiry: exp_r, radius: rad_r, decay: dcy_r};
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt <= cnt_next;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= req_type;
      key_r <= light_key;
      now_r <= now_ms;
      rad_r <= new_radius;
      exp_r <= new_expiry;
      dcy_r <= new_decay;
      ft_r  <= frame_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_addr <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found_key <= 1'b0;
      found_exp <= 1'b0;
    end else if (accept) begin
      found_key <= 1'b0;
      found_exp <= 1'b0;
    end else begin
      if (key_hit && !found_key) begin
        found_key <= 1'b1;
      end
      if (exp_hit && !found_exp) begin
        found_exp <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (key_hit && !found_key) begin
      key_idx <= s1_addr;
    end
    if (exp_hit && !found_exp) begin
      exp_idx <= s1_addr;
    end
  end

  // Result held until the output register can take it.
  always_ff @(posedge clk) begin
    if (accept) begin
      res_idx  <= '0;
      res_code <= OUTC_DONE;
    end else if (scan_end && (req_r == REQ_ALLOC)) begin
      res_idx  <= alloc_idx_ext[SIDX_W-1:0];
      res_code <= alloc_code;
    end
  end

  // Output register: it lets the result beat wait while the next request is accepted.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      slot_index <= res_idx;
      outcome    <= res_code;
    end
  end

endmodule

`default_nettype wire

/* tb/keyed_expiring_light_slot_allocator_unit_tb.sv */
`default_nettype none

module keyed_expiring_light_slot_allocator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kelsa_pkg::*;

  localparam int SLOTS         = NUM_SLOTS_DEF;
  localparam int RANDOM_BEATS  = 1150;
  localparam int HOLD_CYCLES   = 400;
  // An allocate or tick scans the whole table, so this covers any beat still in flight.
  localparam int SETTLE_CYCLES = SLOTS + 8;
  localparam int MAX_PRINTED   = 40;

  // The package names three request codes; the fourth is accepted and answered but does nothing.
  localparam req_t REQ_UNUSED = 2'd3;

  // One request beat as it crosses the input channel.
  typedef struct {
    req_t                req;
    logic [KEY_W-1:0]    key;
    logic [TIME_W-1:0]   now;
    logic [RADIUS_W-1:0] radius;
    logic [TIME_W-1:0]   expiry;
    logic [DECAY_W-1:0]  decay;
    logic [FT_W-1:0]     ft;
  } request_t;

  // One answer beat as it crosses the output channel.
  typedef struct {
    logic [SIDX_W-1:0] slot;
    outc_t             outc;
  } answer_t;

  // The scoreboard keeps its own copy of the light table. Each accepted request updates
  // that copy and queues the answer the block must give; each answer beat is checked
  // against the oldest one still waiting.
  class light_slot_scoreboard #(int N = 32);
    logic [KEY_W-1:0]    key_tab    [N];
    logic [TIME_W-1:0]   expiry_tab [N];
    logic [RADIUS_W-1:0] radius_tab [N];
    logic [DECAY_W-1:0]  decay_tab  [N];
    answer_t             pending_answers [$];
    int                  n_errors;

    function new();
      n_errors = 0;
      wipe();
    endfunction

    function void wipe();
      for (int s = 0; s < N; s++) begin
        key_tab[s]    = '0;
        expiry_tab[s] = '0;
        radius_tab[s] = '0;
        decay_tab[s]  = '0;
      end
    endfunction

    // A live light past its expiry goes dark; every other live light shrinks by
    // decay * frame_time, a Q12.24 product cut back to Q12.8, and stops at zero.
    function void decay_tick(logic [TIME_W-1:0] now, logic [FT_W-1:0] ft);
      logic [PROD_W-1:0] prod;
      logic [PROD_W-1:0] drop;
      for (int s = 0; s < N; s++) begin
        if (radius_tab[s] != '0) begin
          if (expiry_tab[s] < now) begin
            radius_tab[s] = '0;
          end else begin
            prod = PROD_W'(decay_tab[s]) * PROD_W'(ft);
            drop = prod >> FT_W;
            if (drop >= PROD_W'(radius_tab[s])) radius_tab[s] = '0;
            else radius_tab[s] = radius_tab[s] - RADIUS_W'(drop);
          end
        end
      end
    endfunction

    // Slot choice: same nonzero key first, then the lowest expired slot, else slot 0.
    function answer_t allocate(request_t r);
      answer_t a;
      bit      found;
      int      idx;
      found  = 1'b0;
      idx    = 0;
      a.outc = OUTC_FORCED;
      if (r.key != '0) begin
        for (int s = 0; s < N; s++) begin
          if (!found && key_tab[s] == r.key) begin
            idx    = s;
            a.outc = OUTC_KEY_MATCH;
            found  = 1'b1;
          end
        end
      end
      for (int s = 0; s < N; s++) begin
        if (!found && expiry_tab[s] < r.now) begin
          idx    = s;
          a.outc = OUTC_EXPIRED;
          found  = 1'b1;
        end
      end
      key_tab[idx]    = r.key;
      radius_tab[idx] = r.radius;
      expiry_tab[idx] = r.expiry;
      decay_tab[idx]  = r.decay;
      a.slot = SIDX_W'(idx);
      return a;
    endfunction

    function void note_request(request_t r);
      answer_t a;
      a.slot = '0;
      a.outc = OUTC_DONE;
      case (r.req)
        REQ_ALLOC: a = allocate(r);
        REQ_TICK:  decay_tick(r.now, r.ft);
        REQ_CLEAR: wipe();
        default: ;
      endcase
      pending_answers.push_back(a);
    endfunction

    function int pending();
      return pending_answers.size();
    endfunction

    task report(string what);
      n_errors++;
      if (n_errors <= MAX_PRINTED) $display("%0t ns: mismatch: %s", $realtime, what);
    endtask

    task check_answer(logic [SIDX_W-1:0] slot, outc_t outc);
      answer_t want;
      if (pending_answers.size() == 0) begin
        report($sformatf("answer slot %0d outcome %0d with nothing expected", slot, outc));
      end else begin
        want = pending_answers.pop_front();
        if (slot !== want.slot)
          report($sformatf("slot_index %0d, expected %0d", slot, want.slot));
        if (outc !== want.outc)
          report($sformatf("outcome %0d, expected %0d", outc, want.outc));
      end
    endtask
  endclass

  logic                clk        = 1'b0;
  logic                rst        = 1'b1;
  logic                in_valid   = 1'b0;
  logic                in_ready;
  req_t                req_type   = REQ_ALLOC;
  logic [KEY_W-1:0]    light_key  = '0;
  logic [TIME_W-1:0]   now_ms     = '0;
  logic [RADIUS_W-1:0] new_radius = '0;
  logic [TIME_W-1:0]   new_expiry = '0;
  logic [DECAY_W-1:0]  new_decay  = '0;
  logic [FT_W-1:0]     frame_time = '0;
  logic                out_valid;
  logic                out_ready  = 1'b0;
  logic [SIDX_W-1:0]   slot_index;
  outc_t               outcome;

  light_slot_scoreboard #(SLOTS) sb;

  // Running game clock for well-formed traffic; requests mostly use times near it so that
  // expiry compares land on both sides.
  logic [TIME_W-1:0] game_ms = '0;

  // The main process bumps hold_req_id to ask for one long output stall; the receiver
  // remembers which request it last served.
  int hold_req_id = 0;
  int hold_served = 0;
  int hold_left   = 0;
  int stall_mode  = 0;
  int mode_left   = 0;
  int stall_phase = 0;

  keyed_expiring_light_slot_allocator_unit #(
    .NUM_SLOTS(SLOTS)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .light_key  (light_key),
    .now_ms     (now_ms),
    .new_radius (new_radius),
    .new_expiry (new_expiry),
    .new_decay  (new_decay),
    .frame_time (frame_time),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .slot_index (slot_index),
    .outcome    (outcome)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Present one request beat and hold it until the block takes it. On return we sit at
  // the accepting edge, so the caller may either present the next beat or drop valid.
  task automatic send_request(input request_t r);
    in_valid   <= 1'b1;
    req_type   <= r.req;
    light_key  <= r.key;
    now_ms     <= r.now;
    new_radius <= r.radius;
    new_expiry <= r.expiry;
    new_decay  <= r.decay;
    frame_time <= r.ft;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(r);
  endtask

  task automatic idle_input(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_for_answers();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic request_t make_request(req_t req, logic [KEY_W-1:0] key,
                                            logic [TIME_W-1:0] now,
                                            logic [RADIUS_W-1:0] radius,
                                            logic [TIME_W-1:0] expiry,
                                            logic [DECAY_W-1:0] decay,
                                            logic [FT_W-1:0] ft);
    request_t r;
    r.req    = req;
    r.key    = key;
    r.now    = now;
    r.radius = radius;
    r.expiry = expiry;
    r.decay  = decay;
    r.ft     = ft;
    return r;
  endfunction

  // Random traffic. Most beats are allocates and ticks built around the game clock, with
  // keys from a pool a little larger than the table so that matches, expired slots and
  // forced evictions of slot 0 all happen. A few beats are pure noise over the full
  // field ranges, and now and then the clock jumps anywhere in the 32-bit range.
  function automatic request_t random_request();
    request_t r;
    int       roll;
    int       pick;
    roll     = $urandom_range(0, 99);
    r.req    = req_t'($urandom_range(0, 3));
    r.key    = KEY_W'($urandom);
    r.now    = $urandom;
    r.radius = RADIUS_W'($urandom);
    r.expiry = $urandom;
    r.decay  = DECAY_W'($urandom);
    r.ft     = FT_W'($urandom);
    if ($urandom_range(0, 199) == 0) game_ms = $urandom;
    if (roll < 6) begin
      return r;
    end else if (roll < 8) begin
      r.req   = REQ_CLEAR;
      game_ms = $urandom_range(0, 500);
    end else if (roll < 10) begin
      r.req = REQ_UNUSED;
    end else if (roll < 58) begin
      r.req = REQ_ALLOC;
      r.now = game_ms;
      pick  = $urandom_range(0, 99);
      if (pick < 15) r.key = '0;
      else if (pick < 85) r.key = KEY_W'($urandom_range(1, 40));
      pick = $urandom_range(0, 99);
      if (pick < 45) r.expiry = game_ms + $urandom_range(0, 300);
      else if (pick < 75) r.expiry = game_ms + $urandom_range(1000, 200000);
      else if (pick < 85) r.expiry = game_ms - $urandom_range(0, 50);
      pick = $urandom_range(0, 99);
      if (pick < 60) r.radius = RADIUS_W'($urandom_range(1, 'h3FFFF));
      else if (pick < 70) r.radius = '0;
      else if (pick < 80) r.radius = '1;
      pick = $urandom_range(0, 99);
      if (pick < 60) r.decay = DECAY_W'($urandom_range(0, 'h3FFFF));
      else if (pick < 70) r.decay = '0;
      else if (pick < 80) r.decay = '1;
      game_ms = game_ms + $urandom_range(0, 8);
    end else begin
      r.req = REQ_TICK;
      r.now = game_ms;
      if ($urandom_range(0, 99) < 60) r.ft = FT_W'($urandom_range(0, 'h1000));
      game_ms = game_ms + $urandom_range(0, 60);
    end
    return r;
  endfunction

  // Result side: the receiver mostly cycles through stall patterns of its own (always
  // ready, coin flip, mostly stalled, a slow square wave), and on request holds off for
  // a long fixed stretch so that the block backs up and stops taking beats.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_req_id) begin
      hold_served <= hold_req_id;
      hold_left   <= HOLD_CYCLES;
      out_ready   <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(16, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      stall_phase <= stall_phase + 1;
      case (stall_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        2:       out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= stall_phase[2];
      endcase
    end
  end

  // Every answer beat is checked at the edge that moves it.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_answer(slot_index, outcome);
  end

  initial begin
    int  counted;
    int  burst;
    int  gap;
    bit  hold_done;
    bit  first_pause_done;
    bit  second_pause_done;
    request_t r;

    sb                = new();
    counted           = 0;
    hold_done         = 1'b0;
    first_pause_done  = 1'b0;
    second_pause_done = 1'b0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed beats. After reset every expiry is 0, so with now at 0 nothing is expired
    // and a keyless allocate has to evict slot 0. Then: a first use of a key takes an
    // expired slot and a second use finds it again; a tick at full frame time with full
    // decay leaves a sliver of a full radius; a decrement larger than the radius floors
    // at zero; an expiry equal to now is not expired; key 0 never matches the many
    // empty slots that hold key 0; the unused request code; clear; and the top of the
    // time range.
    send_request(make_request(REQ_ALLOC, '0, '0, '1, '1, '1, '0));
    send_request(make_request(REQ_ALLOC, '1, 32'd1, 20'h00100, 32'd1000, '0, '1));
    send_request(make_request(REQ_ALLOC, '1, 32'd5, 20'h00800, 32'd2000, 20'h00100, '0));
    send_request(make_request(REQ_TICK, 16'h1234, '0, '0, '0, '0, '1));
    send_request(make_request(REQ_ALLOC, 16'd2, 32'd3000, 20'd5, 32'd3000, '1, '0));
    send_request(make_request(REQ_TICK, '0, 32'd3000, '1, '1, '1, 16'd1));
    send_request(make_request(REQ_TICK, '0, 32'd3001, '0, '0, '0, '0));
    send_request(make_request(REQ_ALLOC, '0, '0, 20'h12345, 32'h12345678, 20'h54321, '0));
    send_request(make_request(REQ_TICK, '0, '1, '0, '0, '0, '1));
    send_request(make_request(REQ_UNUSED, '1, '1, '1, '1, '1, '1));
    send_request(make_request(REQ_CLEAR, '1, '1, '1, '1, '1, '1));
    send_request(make_request(REQ_ALLOC, 16'd7, '1, 20'h0ABCD, 32'hFFFF_FFFE, 20'h00001, '0));
    send_request(make_request(REQ_ALLOC, 16'd7, '1, '1, '1, '0, '0));
    send_request(make_request(REQ_ALLOC, 16'd8, '1, 20'h00001, '0, '1, '0));
    send_request(make_request(REQ_TICK, '0, '0, '0, '0, '0, '1));
    send_request(make_request(REQ_TICK, '0, '1, '0, '0, '0, 16'h8000));
    send_request(make_request(REQ_CLEAR, '0, '0, '0, '0, '0, '0));
    wait_for_answers();

    // Random traffic in bursts with random gaps; a gap of zero keeps the next burst
    // glued on, which gives long stretches with no idling on the input side.
    while (counted < RANDOM_BEATS) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        r = random_request();
        send_request(r);
        if (r.req != REQ_UNUSED) counted++;
      end
      if (!hold_done && counted >= 350) begin
        // Ask for the long output stall and keep offering beats into it.
        hold_done = 1'b1;
        hold_req_id = hold_req_id + 1;
        repeat (8) begin
          r = random_request();
          send_request(r);
          if (r.req != REQ_UNUSED) counted++;
        end
      end
      if (!first_pause_done && counted >= 700) begin
        first_pause_done = 1'b1;
        wait_for_answers();
      end
      if (!second_pause_done && counted >= 950) begin
        second_pause_done = 1'b1;
        wait_for_answers();
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap != 0) idle_input(gap);
    end

    // Drain, then leave room for any stray answer beat to show up and be flagged.
    wait_for_answers();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.n_errors == 0) begin
      $display("keyed_expiring_light_slot_allocator_unit_tb: done, clean");
    end else begin
      $display("keyed_expiring_light_slot_allocator_unit_tb: done, errors");
    end
    $finish;
  end

  // Watchdog: set far beyond the slowest correct run, even with every beat a full table
  // scan and the receiver stalling hard.
  initial begin
    #4_000_000;
    $display("keyed_expiring_light_slot_allocator_unit_tb: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
